// ===== hdl/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, constants and command/status structs for the sphere
// collision resolver.
// ----------------------------------------------------------------------------
package scr_pkg;

  // field widths
  localparam int COORD_WIDTH_DEF = 32;
  localparam int MASS_W          = 32;
  localparam int RAD_W           = 31;
  localparam int OV_W            = RAD_W + 1;

  // normal is Q1.30 magnitude, mass shares are Q1.32 up to one
  localparam int N_FRAC   = 30;
  localparam int N_MAG_W  = N_FRAC + 1;
  localparam int SH_FRAC  = 32;
  localparam int SH_W     = SH_FRAC + 1;
  localparam int NQ_STEPS = N_MAG_W;
  localparam int SH_STEPS = SH_W;

  localparam logic [N_MAG_W-1:0] N_ONE = N_MAG_W'(1) << N_FRAC;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_END,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_NDIV_GO,
    ST_NDIV_WAIT,
    ST_CHECK,
    ST_SHA_WAIT,
    ST_SHB_GO,
    ST_SHB_WAIT,
    ST_P1,
    ST_P1_END,
    ST_P2,
    ST_P2_END,
    ST_P3,
    ST_P3_END,
    ST_OUT_A,
    ST_OUT_B
  } state_t;

  // multiplier operations
  typedef enum logic [3:0] {
    MOP_SQ,
    MOP_SA,
    MOP_SB,
    MOP_DOT,
    MOP_PA,
    MOP_PB,
    MOP_KA,
    MOP_KB,
    MOP_VA,
    MOP_VB
  } mop_t;

  // iterative unit jobs
  typedef enum logic [1:0] {
    IT_SQRT,
    IT_NDIV,
    IT_SHA,
    IT_SHB
  } it_mode_t;

  typedef struct packed {
    logic     load_a;
    logic     load_b;
    logic     mul_en;
    mop_t     mop;
    logic [1:0] idx;
    logic     it_start;
    logic     it_cap;
    it_mode_t it_mode;
    logic     n_unit;
    logic     set_ov;
    logic     out_b;
  } cmd_t;

  typedef struct packed {
    logic it_done;
    logic dist_zero;
    logic overlap;
    logic dvn_neg;
  } status_t;

endpackage

// ===== hdl/scr_ctrl.sv =====
// ----------------------------------------------------------------------------
// scr_ctrl
// Sequencer for the collision resolver: drives the handshakes and steps the
// datapath through distance, normal, shares, corrections and output.
// ----------------------------------------------------------------------------
module scr_ctrl
  import scr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_second,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output logic    out_last,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] dot_step;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign dot_step = step_r - 3'd2;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.mop      = MOP_SQ;
    cmd.it_mode  = IT_SQRT;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    out_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_second) begin
            cmd.load_b = 1'b1;
            state_nxt  = ST_SQ;
            step_nxt   = '0;
          end else begin
            cmd.load_a = 1'b1;
          end
        end
      end
      ST_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mop    = MOP_SQ;
        cmd.idx    = step_r[1:0];
        if (step_r == 3'd2) begin
          state_nxt = ST_SQ_END;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_SQ_END: state_nxt = ST_SQRT_GO;
      ST_SQRT_GO: begin
        cmd.it_start = 1'b1;
        cmd.it_mode  = IT_SQRT;
        state_nxt    = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        cmd.it_mode = IT_SQRT;
        if (status.it_done) begin
          cmd.it_cap = 1'b1;
          state_nxt  = ST_NDIV_GO;
          step_nxt   = '0;
        end
      end
      ST_NDIV_GO: begin
        // coincident centres take the +x normal
        if (status.dist_zero) begin
          cmd.n_unit = 1'b1;
          state_nxt  = ST_CHECK;
        end else begin
          cmd.it_start = 1'b1;
          cmd.it_mode  = IT_NDIV;
          cmd.idx      = step_r[1:0];
          state_nxt    = ST_NDIV_WAIT;
        end
      end
      ST_NDIV_WAIT: begin
        cmd.it_mode = IT_NDIV;
        cmd.idx     = step_r[1:0];
        if (status.it_done) begin
          cmd.it_cap = 1'b1;
          if (step_r == 3'd2) begin
            state_nxt = ST_CHECK;
          end else begin
            step_nxt  = step_r + 3'd1;
            state_nxt = ST_NDIV_GO;
          end
        end
      end
      ST_CHECK: begin
        if (status.overlap) begin
          cmd.set_ov   = 1'b1;
          cmd.it_start = 1'b1;
          cmd.it_mode  = IT_SHA;
          state_nxt    = ST_SHA_WAIT;
        end else begin
          state_nxt = ST_OUT_A;
        end
      end
      ST_SHA_WAIT: begin
        cmd.it_mode = IT_SHA;
        if (status.it_done) begin
          cmd.it_cap = 1'b1;
          state_nxt  = ST_SHB_GO;
        end
      end
      ST_SHB_GO: begin
        cmd.it_start = 1'b1;
        cmd.it_mode  = IT_SHB;
        state_nxt    = ST_SHB_WAIT;
      end
      ST_SHB_WAIT: begin
        cmd.it_mode = IT_SHB;
        if (status.it_done) begin
          cmd.it_cap = 1'b1;
          state_nxt  = ST_P1;
          step_nxt   = '0;
        end
      end
      // push distances and normal speed
      ST_P1: begin
        cmd.mul_en = 1'b1;
        case (step_r)
          3'd0:    cmd.mop = MOP_SA;
          3'd1:    cmd.mop = MOP_SB;
          default: begin
            cmd.mop = MOP_DOT;
            cmd.idx = dot_step[1:0];
          end
        endcase
        if (step_r == 3'd4) begin
          state_nxt = ST_P1_END;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_P1_END: state_nxt = ST_P2;
      // position moves, then impulse magnitudes
      ST_P2: begin
        cmd.mul_en = 1'b1;
        cmd.idx    = step_r[2:1];
        if (step_r == 3'd6) begin
          cmd.mop = MOP_KA;
        end else if (step_r == 3'd7) begin
          cmd.mop = MOP_KB;
        end else begin
          cmd.mop = step_r[0] ? MOP_PB : MOP_PA;
        end
        if (step_r == 3'd7) begin
          state_nxt = ST_P2_END;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_P2_END: begin
        if (status.dvn_neg) state_nxt = ST_OUT_A;
        else                state_nxt = ST_P3;
      end
      // velocity changes
      ST_P3: begin
        cmd.mul_en = 1'b1;
        cmd.idx    = step_r[2:1];
        cmd.mop    = step_r[0] ? MOP_VB : MOP_VA;
        if (step_r == 3'd5) begin
          state_nxt = ST_P3_END;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_P3_END: state_nxt = ST_OUT_A;
      ST_OUT_A: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_OUT_B;
      end
      ST_OUT_B: begin
        out_tvalid = 1'b1;
        out_last   = 1'b1;
        cmd.out_b  = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/scr_iter.sv =====
// ----------------------------------------------------------------------------
// scr_iter
// Shared iterative unit: restoring square root (two radicand bits a step)
// and restoring division (one quotient bit a step).
// ----------------------------------------------------------------------------
module scr_iter
  import scr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int DW   = COORD_WIDTH + 1,
  localparam int D2W  = 2 * DW,
  localparam int VW   = (DW > SH_W) ? DW : SH_W,
  localparam int CNTW = $clog2(VW + 1)
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            sqrt_mode,
  input  logic [CNTW-1:0] nsteps,
  input  logic [D2W-1:0]  radicand,
  input  logic [VW-1:0]   dividend,
  input  logic [VW-1:0]   divisor,
  output logic            done,
  output logic [VW-1:0]   result
);

  localparam int RMW = (DW + 3 > VW + 1) ? DW + 3 : VW + 1;

  logic            busy_r, done_r, sq_r;
  logic [CNTW-1:0] cnt_r;
  logic [RMW-1:0]  rem_r;
  logic [VW-1:0]   q_r;
  logic [D2W-1:0]  rad_r;
  logic [VW-1:0]   dvs_r;

  logic [RMW-1:0] sq_rem, sq_trial, div_sub;
  logic           sq_ge, div_ge;

  // one step of either operation
  always_comb begin
    sq_rem   = {rem_r[RMW-3:0], rad_r[D2W-1 -: 2]};
    sq_trial = RMW'({q_r[DW-1:0], 2'b01});
    sq_ge    = sq_rem >= sq_trial;
    div_ge   = rem_r >= RMW'(dvs_r);
    div_sub  = div_ge ? rem_r - RMW'(dvs_r) : rem_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nsteps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      sq_r  <= sqrt_mode;
      rem_r <= sqrt_mode ? '0 : RMW'(dividend);
      q_r   <= '0;
      rad_r <= radicand;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (sq_r) begin
        rem_r <= sq_ge ? sq_rem - sq_trial : sq_rem;
        q_r   <= {q_r[VW-2:0], sq_ge};
        rad_r <= {rad_r[D2W-3:0], 2'b00};
      end else begin
        rem_r <= {div_sub[RMW-2:0], 1'b0};
        q_r   <= {q_r[VW-2:0], div_ge};
      end
    end
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

// ===== hdl/scr_dp.sv =====
// ----------------------------------------------------------------------------
// scr_dp
// Datapath: held body A, working copies of both bodies, one shared
// multiplier with a product register, accumulators and the iterative unit.
// ----------------------------------------------------------------------------
module scr_dp
  import scr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic signed [COORD_WIDTH-1:0] in_pos [3],
  input  logic signed [COORD_WIDTH-1:0] in_vel [3],
  input  logic [MASS_W-1:0]             in_mass,
  input  logic [RAD_W-1:0]              in_rad,
  output logic signed [COORD_WIDTH-1:0] out_pos [3],
  output logic signed [COORD_WIDTH-1:0] out_vel [3],
  output logic                          out_ov
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int D2W  = 2 * DW;
  localparam int VW   = (DW > SH_W) ? DW : SH_W;
  localparam int CNTW = $clog2(VW + 1);
  localparam int KW   = DW + 2;
  localparam int MAW  = (KW > OV_W) ? KW : OV_W;
  localparam int MBW  = VW;
  localparam int PW   = MAW + MBW;
  localparam int TW   = DW + N_FRAC + 3;
  localparam int UPW  = MAW + 2;
  localparam int CMPW = (DW > OV_W) ? DW : OV_W;

  // held body A
  logic signed [CW-1:0] hpos_r [3];
  logic signed [CW-1:0] hvel_r [3];
  logic [MASS_W-1:0]    hmass_r;
  logic [RAD_W-1:0]     hrad_r;

  // working state
  logic [MASS_W-1:0]     mb_r;
  logic [RAD_W-1:0]      rb_r;
  logic signed [UPW-1:0] pa_r [3];
  logic signed [UPW-1:0] pb_r [3];
  logic signed [UPW-1:0] va_r [3];
  logic signed [UPW-1:0] vb_r [3];
  logic signed [DW-1:0]  d_r [3];
  logic [D2W-1:0]        d2_r;
  logic [DW-1:0]         dist_r;
  logic [N_MAG_W-1:0]    nmag_r [3];
  logic [2:0]            nneg_r;
  logic [SH_W-1:0]       sha_r, shb_r;
  logic [OV_W-1:0]       sa_r, sb_r;
  logic signed [TW-1:0]  t_r;
  logic [KW-1:0]         ka_r, kb_r;
  logic                  ov_r;

  // multiplier stage
  logic [PW-1:0] prod_r;
  logic          pneg_r, pend_r;
  mop_t          pmop_r;
  logic [1:0]    pidx_r;

  logic [MAW-1:0]  mul_a;
  logic [MBW-1:0]  mul_b;
  logic            mul_neg;
  logic [DW-1:0]   dmag [3];
  logic [DW-1:0]   dv_raw, dvmag;
  logic            dvneg;
  logic [OV_W-1:0] rs, over;
  logic [CMPW-1:0] over_full;
  logic [SH_W-1:0] total;
  logic [KW-1:0]   dvn2;
  logic signed [UPW-1:0] msh, delta;
  logic signed [TW-1:0]  pt;

  logic            it_done;
  logic [VW-1:0]   it_res, it_dividend, it_divisor;
  logic [CNTW-1:0] it_steps;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [UPW-1:0] v);
    if (v[UPW-1:CW-1] == '0 || v[UPW-1:CW-1] == '1) begin
      return v[CW-1:0];
    end else if (v[UPW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // derived scalars
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = d_r[i][DW-1] ? DW'(-d_r[i]) : DW'(d_r[i]);
    end
    rs        = OV_W'(hrad_r) + OV_W'(rb_r);
    over_full = CMPW'(rs) - CMPW'(dist_r);
    over      = over_full[OV_W-1:0];
    total     = SH_W'(hmass_r) + SH_W'(mb_r);
    dvn2      = {t_r[N_FRAC + KW - 2 : N_FRAC], 1'b0};
    dv_raw    = DW'(va_r[cmd.idx] - vb_r[cmd.idx]);
    dvneg     = dv_raw[DW-1];
    dvmag     = dvneg ? DW'(-dv_raw) : dv_raw;
  end

  assign status.it_done   = it_done;
  assign status.dist_zero = (dist_r == '0);
  assign status.overlap   = CMPW'(dist_r) < CMPW'(rs);
  assign status.dvn_neg   = t_r[TW-1];

  // multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd.mop)
      MOP_SQ: begin
        mul_a = MAW'(dmag[cmd.idx]);
        mul_b = MBW'(dmag[cmd.idx]);
      end
      MOP_SA: begin
        mul_a = MAW'(over);
        mul_b = MBW'(sha_r);
      end
      MOP_SB: begin
        mul_a = MAW'(over);
        mul_b = MBW'(shb_r);
      end
      MOP_DOT: begin
        mul_a   = MAW'(dvmag);
        mul_b   = MBW'(nmag_r[cmd.idx]);
        mul_neg = dvneg ^ nneg_r[cmd.idx];
      end
      MOP_PA: begin
        mul_a   = MAW'(sa_r);
        mul_b   = MBW'(nmag_r[cmd.idx]);
        mul_neg = nneg_r[cmd.idx];
      end
      MOP_PB: begin
        mul_a   = MAW'(sb_r);
        mul_b   = MBW'(nmag_r[cmd.idx]);
        mul_neg = nneg_r[cmd.idx];
      end
      MOP_KA: begin
        mul_a = MAW'(dvn2);
        mul_b = MBW'(sha_r);
      end
      MOP_KB: begin
        mul_a = MAW'(dvn2);
        mul_b = MBW'(shb_r);
      end
      MOP_VA: begin
        mul_a   = MAW'(ka_r);
        mul_b   = MBW'(nmag_r[cmd.idx]);
        mul_neg = nneg_r[cmd.idx];
      end
      MOP_VB: begin
        mul_a   = MAW'(kb_r);
        mul_b   = MBW'(nmag_r[cmd.idx]);
        mul_neg = nneg_r[cmd.idx];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // signed terms from the registered product
  always_comb begin
    msh   = $signed(prod_r[N_FRAC +: UPW]);
    delta = pneg_r ? -msh : msh;
    pt    = $signed(prod_r[TW-1:0]);
  end

  // iterative unit operands
  always_comb begin
    it_dividend = VW'(dmag[cmd.idx]);
    it_divisor  = VW'(dist_r);
    it_steps    = CNTW'(NQ_STEPS);
    case (cmd.it_mode)
      IT_SQRT: it_steps = CNTW'(DW);
      IT_SHA: begin
        it_dividend = VW'(mb_r);
        it_divisor  = VW'(total);
        it_steps    = CNTW'(SH_STEPS);
      end
      IT_SHB: begin
        it_dividend = VW'(hmass_r);
        it_divisor  = VW'(total);
        it_steps    = CNTW'(SH_STEPS);
      end
      default: it_steps = CNTW'(NQ_STEPS);
    endcase
  end

  scr_iter #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.it_start),
    .sqrt_mode (cmd.it_mode == IT_SQRT),
    .nsteps    (it_steps),
    .radicand  (d2_r),
    .dividend  (it_dividend),
    .divisor   (it_divisor),
    .done      (it_done),
    .result    (it_res)
  );

  // held body A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        hpos_r[i] <= '0;
        hvel_r[i] <= '0;
      end
      hmass_r <= '0;
      hrad_r  <= '0;
    end else if (cmd.load_a) begin
      for (int i = 0; i < 3; i++) begin
        hpos_r[i] <= in_pos[i];
        hvel_r[i] <= in_vel[i];
      end
      hmass_r <= in_mass;
      hrad_r  <= in_rad;
    end
  end

  // product pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else        pend_r <= cmd.mul_en;
  end

  // multiplier and working registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
      pneg_r <= mul_neg;
      pmop_r <= cmd.mop;
      pidx_r <= cmd.idx;
    end

    if (cmd.load_b) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= UPW'(hpos_r[i]);
        va_r[i] <= UPW'(hvel_r[i]);
        pb_r[i] <= UPW'(in_pos[i]);
        vb_r[i] <= UPW'(in_vel[i]);
        d_r[i]  <= DW'(in_pos[i]) - DW'(hpos_r[i]);
      end
      mb_r <= in_mass;
      rb_r <= in_rad;
      d2_r <= '0;
      t_r  <= '0;
      ov_r <= 1'b0;
    end

    if (cmd.set_ov) ov_r <= 1'b1;

    if (cmd.n_unit) begin
      nmag_r[0] <= N_ONE;
      nmag_r[1] <= '0;
      nmag_r[2] <= '0;
      nneg_r    <= '0;
    end

    // capture iterative results
    if (cmd.it_cap) begin
      case (cmd.it_mode)
        IT_SQRT: dist_r <= it_res[DW-1:0];
        IT_NDIV: begin
          nmag_r[cmd.idx] <= it_res[N_MAG_W-1:0];
          nneg_r[cmd.idx] <= d_r[cmd.idx][DW-1];
        end
        IT_SHA:  sha_r <= (total == '0) ? '0 : it_res[SH_W-1:0];
        IT_SHB:  shb_r <= (total == '0) ? '0 : it_res[SH_W-1:0];
        default: dist_r <= it_res[DW-1:0];
      endcase
    end

    // act on the registered product
    if (pend_r) begin
      case (pmop_r)
        MOP_SQ:  d2_r <= d2_r + prod_r[D2W-1:0];
        MOP_SA:  sa_r <= prod_r[SH_FRAC +: OV_W];
        MOP_SB:  sb_r <= prod_r[SH_FRAC +: OV_W];
        MOP_DOT: t_r  <= pneg_r ? t_r - pt : t_r + pt;
        MOP_PA:  pa_r[pidx_r] <= pa_r[pidx_r] - delta;
        MOP_PB:  pb_r[pidx_r] <= pb_r[pidx_r] + delta;
        MOP_KA:  ka_r <= prod_r[SH_FRAC +: KW];
        MOP_KB:  kb_r <= prod_r[SH_FRAC +: KW];
        MOP_VA:  va_r[pidx_r] <= va_r[pidx_r] - delta;
        MOP_VB:  vb_r[pidx_r] <= vb_r[pidx_r] + delta;
        default: d2_r <= d2_r;
      endcase
    end
  end

  // saturated result fields
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_pos[i] = cmd.out_b ? sat_cw(pb_r[i]) : sat_cw(pa_r[i]);
      out_vel[i] = cmd.out_b ? sat_cw(vb_r[i]) : sat_cw(va_r[i]);
    end
  end

  assign out_ov = ov_r;

endmodule

// ===== hdl/sphere_collision_resolve.sv =====
// Body A items are taken and give no result.
// A body B item starts resolution: the A result is shown first, and the B
// result follows once A is taken. One pair is resolved at a time: no new item
// is taken until both results are out. Resolution uses the one-bit-per-cycle
// square root and up to five divisions in scr_iter.
// Synchronous active-low reset clears the held body and returns to idle.
// ----------------------------------------------------------------------------
// sphere_collision_resolve
// Elastic collision of two spheres in Q16.16: when they overlap, position correction along the
// normal and an impulse when the bodies approach.
// ----------------------------------------------------------------------------
module sphere_collision_resolve
  import scr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_BITS = 6 * COORD_WIDTH + MASS_W + RAD_W,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((6 * COORD_WIDTH + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // body_pos_x, body_pos_y, body_pos_z, body_vel_x, body_vel_y, body_vel_z,
  // body_mass, body_radius, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  // is_second
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z, zero fill
  output logic [OUT_W-1:0] out_tdata,
  // which_body, overlapped
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int CW = COORD_WIDTH;

  status_t status;
  cmd_t    cmd;
  logic    out_ov;

  logic signed [CW-1:0] in_pos [3];
  logic signed [CW-1:0] in_vel [3];
  logic signed [CW-1:0] res_pos [3];
  logic signed [CW-1:0] res_vel [3];

  // unpack input item
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = $signed(in_tdata[i * CW +: CW]);
      in_vel[i] = $signed(in_tdata[(i + 3) * CW +: CW]);
    end
  end

  scr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_second  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_last   (out_tlast),
    .status     (status),
    .cmd        (cmd)
  );

  scr_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .status  (status),
    .in_pos  (in_pos),
    .in_vel  (in_vel),
    .in_mass (in_tdata[6 * CW +: MASS_W]),
    .in_rad  (in_tdata[6 * CW + MASS_W +: RAD_W]),
    .out_pos (res_pos),
    .out_vel (res_vel),
    .out_ov  (out_ov)
  );

  // pack result item
  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      out_tdata[i * CW +: CW]       = res_pos[i];
      out_tdata[(i + 3) * CW +: CW] = res_vel[i];
    end
  end

  assign out_tuser = {out_ov, out_tlast};

  // checks
  a_no_overlap_io: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is shown");

  a_idle_after_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not idle after the second result");

  a_b_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready && !out_tvalid)
    else $error("body B did not start resolution");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("body B result does not follow body A");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere collision resolver: body A and body B
// items go in with random bursts and gaps, a scoreboard predicts the updated
// pair in bit-exact fixed point and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import scr_pkg::*;

  localparam int CW    = 32;
  localparam int IN_W  = ((6 * CW + MASS_W + RAD_W + 7) / 8) * 8;
  localparam int OUT_W = ((6 * CW + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CW-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [1:0]    which_ov;
    logic          last;
  } body_res_t;

  // collision predictor with its own copy of the held body A
  class collision_scoreboard;
    logic signed [63:0] hold_pos[3], hold_vel[3];
    logic [63:0]        hold_mass, hold_rad;
    body_res_t          pending[$];
    int                 errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        hold_pos[i] = 0;
        hold_vel[i] = 0;
      end
      hold_mass = 0;
      hold_rad  = 0;
      errors    = 0;
    endfunction

    // (a*b) >> sh, saturating to all ones when it does not fit in 64 bits
    function logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> sh;
      if (p[127:64] != 0) return '1;
      return p[63:0];
    endfunction

    function logic signed [63:0] sgn(logic signed [63:0] s, logic [63:0] m);
      return (s < 0) ? -$signed(m) : $signed(m);
    endfunction

    function logic [63:0] absv(logic signed [63:0] v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [CW-1:0] clamp(logic signed [63:0] v);
      if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (v < -64'sh80000000) return 32'h80000000;
      return v[CW-1:0];
    endfunction

    // floor division of a signed 128-bit value by 2^30
    function logic signed [63:0] floor30(logic signed [127:0] v);
      logic signed [127:0] q;
      q = v >>> 30;
      return q[63:0];
    endfunction

    function void note_item(logic [IN_W-1:0] d, logic second);
      logic signed [63:0] pa[3], va[3], pb[3], vb[3], n[3], dd[3];
      logic [127:0] d2, c2;
      logic [63:0]  ma, mb, ra, rb, root, rs, over, total, sha, shb, sa, sb, ka, kb;
      logic [127:0] num;
      logic signed [127:0] dot;
      logic signed [63:0] dvn;
      logic ov;
      body_res_t r;
      if (!second) begin
        for (int i = 0; i < 3; i++) begin
          hold_pos[i] = $signed(d[i*CW +: CW]);
          hold_vel[i] = $signed(d[(3+i)*CW +: CW]);
        end
        hold_mass = d[6*CW +: 32];
        hold_rad  = d[6*CW+32 +: 31];
        return;
      end
      ma = hold_mass;
      ra = hold_rad;
      mb = d[6*CW +: 32];
      rb = d[6*CW+32 +: 31];
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        pa[i] = hold_pos[i];
        va[i] = hold_vel[i];
        pb[i] = $signed(d[i*CW +: CW]);
        vb[i] = $signed(d[(3+i)*CW +: CW]);
        dd[i] = pb[i] - pa[i];
        d2 += {64'd0, absv(dd[i])} * {64'd0, absv(dd[i])};
      end
      // bitwise integer square root
      root = 0;
      for (int b = 34; b >= 0; b--) begin
        c2 = {64'd0, root | (64'd1 << b)} * {64'd0, root | (64'd1 << b)};
        if (c2 <= d2) root = root | (64'd1 << b);
      end
      rs = ra + rb;
      if (root == 0) begin
        n[0] = 64'sd1 << 30;
        n[1] = 0;
        n[2] = 0;
      end else begin
        for (int i = 0; i < 3; i++) n[i] = sgn(dd[i], (absv(dd[i]) << 30) / root);
      end
      ov = root < rs;
      if (ov) begin
        over  = rs - root;
        total = ma + mb;
        sha = 0;
        shb = 0;
        if (total != 0) begin
          num = {64'd0, mb} << 32;
          sha = num / total;
          num = {64'd0, ma} << 32;
          shb = num / total;
        end
        sa = mulsh(over, sha, 32);
        sb = mulsh(over, shb, 32);
        dot = 0;
        for (int i = 0; i < 3; i++) dot += 128'(va[i] - vb[i]) * 128'(n[i]);
        dvn = floor30(dot);
        for (int i = 0; i < 3; i++) begin
          pa[i] -= sgn(n[i], mulsh(sa, absv(n[i]), 30));
          pb[i] += sgn(n[i], mulsh(sb, absv(n[i]), 30));
        end
        // approaching bodies get the impulse
        if (dvn >= 0) begin
          ka = mulsh(dvn * 2, sha, 32);
          kb = mulsh(dvn * 2, shb, 32);
          for (int i = 0; i < 3; i++) begin
            va[i] -= sgn(n[i], mulsh(ka, absv(n[i]), 30));
            vb[i] += sgn(n[i], mulsh(kb, absv(n[i]), 30));
          end
        end
      end
      for (int k = 0; k < 2; k++) begin
        r.pos_x = clamp(k ? pb[0] : pa[0]);
        r.pos_y = clamp(k ? pb[1] : pa[1]);
        r.pos_z = clamp(k ? pb[2] : pa[2]);
        r.vel_x = clamp(k ? vb[0] : va[0]);
        r.vel_y = clamp(k ? vb[1] : va[1]);
        r.vel_z = clamp(k ? vb[2] : va[2]);
        r.which_ov = {ov, k[0]};
        r.last = k[0];
        pending.push_back(r);
      end
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] d, logic [1:0] u, logic l);
      body_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: data %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("out_pos_x", e.pos_x, d[0*CW +: CW]);
      cmp("out_pos_y", e.pos_y, d[1*CW +: CW]);
      cmp("out_pos_z", e.pos_z, d[2*CW +: CW]);
      cmp("out_vel_x", e.vel_x, d[3*CW +: CW]);
      cmp("out_vel_y", e.vel_y, d[4*CW +: CW]);
      cmp("out_vel_z", e.vel_z, d[5*CW +: CW]);
      cmp("which_body", e.which_ov[0], u[0]);
      cmp("overlapped", e.which_ov[1], u[1]);
      cmp("last_of_pair", e.last, l);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;

  collision_scoreboard sb = new();
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  hold_off = 1'b0;

  sphere_collision_resolve u_top (.*);

  always #2 clk = ~clk;

  // scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // receiver stall pattern, with a long hold-off while hold_off is set
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (burst_left > 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      burst_left = $urandom_range(0, 300);
      repeat (burst_left) @(posedge clk);
      burst_left = 0;
    end
  end

  // one item onto the input, in gap mode sometimes with a random gap before it
  task automatic send_body(logic [IN_W-1:0] data, logic second, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= second;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_body(logic [31:0] px, py, pz, vx, vy, vz,
                                                 logic [31:0] m, logic [30:0] r);
    logic [IN_W-1:0] d;
    d = '0;
    d[0 +: 192] = {vz, vy, vx, pz, py, px};
    d[192 +: 32] = m;
    d[224 +: 31] = r;
    return d;
  endfunction

  // body near a given point so that spheres overlap often
  function automatic logic [IN_W-1:0] near_body(logic [31:0] cx, cy, cz, bit full);
    logic [31:0] off[3], v[3], m;
    logic [30:0] r;
    for (int i = 0; i < 3; i++) begin
      off[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      v[i] = full ? $urandom() : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    m = full ? $urandom() : $urandom_range(1, 1 << 22);
    r = full ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
    return pack_body(cx + off[0], cy + off[1], cz + off[2], v[0], v[1], v[2], m, r);
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] cx, cy, cz;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: B before any A, coincident centres, extremes
    send_body(pack_body(0, 0, 0, 0, 0, 0, 32'h10000, 31'h10000), 1'b1, 1'b0);
    send_body(pack_body(0, 0, 0, 0, 0, 0, 32'h0, 31'h0), 1'b0, 1'b0);
    send_body(pack_body(0, 0, 0, 0, 0, 0, 32'h0, 31'h0), 1'b1, 1'b0);
    send_body(pack_body(32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000, 31'h10000),
              1'b0, 1'b0);
    send_body(pack_body(32'h10000, 0, 0, 0, 0, 0, 32'h20000, 31'h8000), 1'b1, 1'b0);
    send_body(pack_body(32'h18000, 0, 0, 32'hFFFF0000, 0, 0, 32'h10000, 31'h10000),
              1'b1, 1'b0);
    send_body(pack_body(32'h18000, 0, 0, 32'h00010000, 0, 0, 32'h10000, 31'h10000),
              1'b1, 1'b0);
    send_body(pack_body(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'hFFFFFFFF, 31'h7FFFFFFF), 1'b0, 1'b0);
    send_body(pack_body(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF), 1'b1, 1'b0);
    send_body(pack_body(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF,
              32'h80000000, 32'h1, 32'h1, 31'h7FFFFFFF), 1'b1, 1'b0);
    send_body(pack_body(0, 0, 0, 0, 0, 0, 32'h1, 31'h0), 1'b0, 1'b0);
    send_body(pack_body(0, 0, 32'h100, 0, 0, 32'h80000000, 32'hFFFFFFFF, 31'h0),
              1'b1, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering pairs
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int p = 0; p < 6; p++) begin
        send_body(near_body(0, 0, 0, 1'b0), 1'b0, 1'b0);
        send_body(near_body(0, 0, 0, 1'b0), 1'b1, 1'b0);
      end
    join
    wait_drained();

    // random: mostly A-B pairs near each other, some noise and odd sequences
    for (int it = 0; it < 485; it++) begin
      cx = $urandom();
      cy = $urandom();
      cz = $urandom();
      case ($urandom_range(0, 9))
        0: send_body(pack_body(rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), 31'(rand_word())),
                     1'($urandom_range(0, 1)), 1'b1);
        1: begin
          send_body(near_body(cx, cy, cz, 1'b1), 1'b0, 1'b1);
          send_body(near_body(cx, cy, cz, 1'b1), 1'b1, 1'b1);
        end
        2: send_body(near_body(cx, cy, cz, 1'b0), 1'b1, 1'b1);
        default: begin
          send_body(near_body(cx, cy, cz, 1'b0), 1'b0, it % 64 >= 16);
          send_body(near_body(cx, cy, cz, 1'b0), 1'b1, it % 64 >= 16);
        end
      endcase
      if (it == 240) wait_drained();
    end
    wait_drained();
    repeat (300) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sphere_collision_resolve.f =====
hdl/scr_pkg.sv
hdl/scr_ctrl.sv
hdl/scr_iter.sv
hdl/scr_dp.sv
hdl/sphere_collision_resolve.sv
tb/tb_top.sv
